>>> rtl/core/csl_pkg.sv
// csl_pkg: token kinds, error codes, sizes and character helpers for the lexer
// used by csl_core and c_subset_lexer; no dependencies
package csl_pkg;

  localparam int PosBits  = 16;
  localparam int LineBits = 16;
  localparam int KeyChars = 6;
  localparam int KeyLenW  = $clog2(KeyChars + 2);

  localparam logic [5:0] KId       = 6'd0;
  localparam logic [5:0] KKwInt    = 6'd1;
  localparam logic [5:0] KKwChar   = 6'd2;
  localparam logic [5:0] KKwElse   = 6'd3;
  localparam logic [5:0] KKwIf     = 6'd4;
  localparam logic [5:0] KKwReturn = 6'd5;
  localparam logic [5:0] KKwStruct = 6'd6;
  localparam logic [5:0] KKwVoid   = 6'd7;
  localparam logic [5:0] KKwWhile  = 6'd8;
  localparam logic [5:0] KInt      = 6'd9;
  localparam logic [5:0] KDouble   = 6'd10;
  localparam logic [5:0] KChar     = 6'd11;
  localparam logic [5:0] KString   = 6'd12;
  localparam logic [5:0] KComma    = 6'd13;
  localparam logic [5:0] KSemi     = 6'd14;
  localparam logic [5:0] KLpar     = 6'd15;
  localparam logic [5:0] KRpar     = 6'd16;
  localparam logic [5:0] KLbrk     = 6'd17;
  localparam logic [5:0] KRbrk     = 6'd18;
  localparam logic [5:0] KLacc     = 6'd19;
  localparam logic [5:0] KRacc     = 6'd20;
  localparam logic [5:0] KEnd      = 6'd21;
  localparam logic [5:0] KAdd      = 6'd22;
  localparam logic [5:0] KSub      = 6'd23;
  localparam logic [5:0] KMul      = 6'd24;
  localparam logic [5:0] KDiv      = 6'd25;
  localparam logic [5:0] KAnd      = 6'd26;
  localparam logic [5:0] KOr       = 6'd27;
  localparam logic [5:0] KNot      = 6'd28;
  localparam logic [5:0] KAssign   = 6'd29;
  localparam logic [5:0] KEqual    = 6'd30;
  localparam logic [5:0] KNoteq    = 6'd31;
  localparam logic [5:0] KLess     = 6'd32;
  localparam logic [5:0] KLesseq   = 6'd33;
  localparam logic [5:0] KGreater  = 6'd34;
  localparam logic [5:0] KGreatereq = 6'd35;
  localparam logic [5:0] KError    = 6'd36;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrAmp    = 3'd1;
  localparam logic [2:0] ErrBar    = 3'd2;
  localparam logic [2:0] ErrQuote  = 3'd3;
  localparam logic [2:0] ErrDquote = 3'd4;
  localparam logic [2:0] ErrChar   = 3'd5;

  localparam logic [30:0] IntTop = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [30:0] ival;
    logic [7:0]  cval;
    logic [15:0] start;
    logic [15:0] len;
    logic [2:0]  err;
  } token_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

>>> rtl/core/csl_core.sv
// csl_core: per-byte lexer state update, up to two tokens per byte
// depends on csl_pkg
module csl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  output logic              tok0_vld_o,
  output csl_pkg::token_t   tok0_o,
  output logic              tok1_vld_o,
  output csl_pkg::token_t   tok1_o
);

  typedef enum logic [4:0] {
    MStart, MIdent, MInt, MFrac, MExps, MExpd1, MExp, MSlash, MComment,
    MAmp, MBar, MBang, MLt, MGt, MEq, MChar1, MChar2, MString, MDrop
  } mode_e;

  localparam logic [csl_pkg::LineBits-1:0] LineTop = '1;

  mode_e mode_q, mode_d;
  logic [csl_pkg::LineBits-1:0] line_q, line_d;
  logic [csl_pkg::PosBits-1:0]  pos_q, pos_d, tstart_q, tstart_d;
  logic [30:0] acc_q, acc_d;
  logic [7:0]  kbuf_q [csl_pkg::KeyChars];
  logic [7:0]  kbuf_d [csl_pkg::KeyChars];
  logic [csl_pkg::KeyLenW-1:0] ilen_q, ilen_d;
  logic cr_q, cr_d;
  logic [7:0] lit_q, lit_d;

  function automatic logic [5:0] kw_kind(input logic [7:0] b [csl_pkg::KeyChars],
                                         input logic [csl_pkg::KeyLenW-1:0] n);
    logic [5:0] k;
    k = csl_pkg::KId;
    if (n == 3 && b[0] == "i" && b[1] == "n" && b[2] == "t") k = csl_pkg::KKwInt;
    if (n == 4 && b[0] == "c" && b[1] == "h" && b[2] == "a" && b[3] == "r")
      k = csl_pkg::KKwChar;
    if (n == 4 && b[0] == "e" && b[1] == "l" && b[2] == "s" && b[3] == "e")
      k = csl_pkg::KKwElse;
    if (n == 2 && b[0] == "i" && b[1] == "f") k = csl_pkg::KKwIf;
    if (n == 6 && b[0] == "r" && b[1] == "e" && b[2] == "t" && b[3] == "u" &&
        b[4] == "r" && b[5] == "n") k = csl_pkg::KKwReturn;
    if (n == 6 && b[0] == "s" && b[1] == "t" && b[2] == "r" && b[3] == "u" &&
        b[4] == "c" && b[5] == "t") k = csl_pkg::KKwStruct;
    if (n == 4 && b[0] == "v" && b[1] == "o" && b[2] == "i" && b[3] == "d")
      k = csl_pkg::KKwVoid;
    if (n == 5 && b[0] == "w" && b[1] == "h" && b[2] == "i" && b[3] == "l" &&
        b[4] == "e") k = csl_pkg::KKwWhile;
    return k;
  endfunction

  logic [34:0] acc_x10;
  logic [35:0] acc_sum;
  logic [7:0]  dig;
  logic [csl_pkg::PosBits-1:0] span;
  logic restart, new_cr, pend, ov1;
  csl_pkg::token_t t0, t1;
  logic v0, v1;

  assign dig     = char_i - 8'h30;
  assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum = {1'b0, acc_x10} + {28'd0, dig};
  assign span    = pos_q - tstart_q;

  always_comb begin
    mode_d = mode_q; line_d = line_q; tstart_d = tstart_q; acc_d = acc_q;
    kbuf_d = kbuf_q; ilen_d = ilen_q; lit_d = lit_q;
    restart = 1'b0; new_cr = 1'b0; pend = 1'b0;
    v0 = 1'b0; v1 = 1'b0;
    t0 = '0; t0.line = 16'(line_q); t0.start = 16'(tstart_q);
    t1 = '0;
    // first pass: pending token finishes or byte is consumed by the mode
    case (mode_q)
      MIdent: begin
        if (csl_pkg::is_alpha(char_i) || csl_pkg::is_digit(char_i)) begin
          for (int i = 0; i < csl_pkg::KeyChars; i++)
            if (ilen_q == csl_pkg::KeyLenW'(i)) kbuf_d[i] = char_i;
          if (ilen_q <= csl_pkg::KeyLenW'(csl_pkg::KeyChars)) ilen_d = ilen_q + 1'b1;
        end else begin
          v0 = 1'b1; pend = 1'b1; t0.len = 16'(span);
          t0.kind = (ilen_q <= csl_pkg::KeyLenW'(csl_pkg::KeyChars)) ?
                    kw_kind(kbuf_q, ilen_q) : csl_pkg::KId;
        end
      end
      MInt: begin
        if (csl_pkg::is_digit(char_i)) begin
          acc_d = (acc_sum > {5'd0, csl_pkg::IntTop}) ? csl_pkg::IntTop : acc_sum[30:0];
        end else if (char_i == ".") mode_d = MFrac;
        else if (char_i == "e" || char_i == "E") mode_d = MExps;
        else begin
          v0 = 1'b1; pend = 1'b1; t0.kind = csl_pkg::KInt; t0.ival = acc_q;
          t0.len = 16'(span);
        end
      end
      MFrac: begin
        if (char_i == "e" || char_i == "E") mode_d = MExps;
        else if (!csl_pkg::is_digit(char_i)) begin
          v0 = 1'b1; pend = 1'b1; t0.kind = csl_pkg::KDouble; t0.len = 16'(span);
        end
      end
      MExps: begin
        if (char_i == "+" || char_i == "-") mode_d = MExpd1;
        else if (csl_pkg::is_digit(char_i)) mode_d = MExp;
        else begin
          v0 = 1'b1; pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrChar;
        end
      end
      MExpd1: begin
        if (csl_pkg::is_digit(char_i)) mode_d = MExp;
        else begin
          v0 = 1'b1; pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrChar;
        end
      end
      MExp: begin
        if (!csl_pkg::is_digit(char_i)) begin
          v0 = 1'b1; pend = 1'b1; t0.kind = csl_pkg::KDouble; t0.len = 16'(span);
        end
      end
      MSlash: begin
        if (char_i == "/") mode_d = MComment;
        else begin v0 = 1'b1; pend = 1'b1; t0.kind = csl_pkg::KDiv; end
      end
      MComment: begin
        if (char_i == 8'h00 || char_i == 8'h0D || char_i == 8'h0A) pend = 1'b1;
      end
      MAmp: begin
        v0 = 1'b1;
        if (char_i == "&") begin t0.kind = csl_pkg::KAnd; mode_d = MStart; end
        else begin
          pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrAmp;
        end
      end
      MBar: begin
        v0 = 1'b1;
        if (char_i == "|") begin t0.kind = csl_pkg::KOr; mode_d = MStart; end
        else begin
          pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrBar;
        end
      end
      MBang, MLt, MGt, MEq: begin
        v0 = 1'b1;
        if (char_i == "=") begin
          mode_d = MStart;
          case (mode_q)
            MBang:   t0.kind = csl_pkg::KNoteq;
            MLt:     t0.kind = csl_pkg::KLesseq;
            MGt:     t0.kind = csl_pkg::KGreatereq;
            default: t0.kind = csl_pkg::KEqual;
          endcase
        end else begin
          pend = 1'b1;
          case (mode_q)
            MBang:   t0.kind = csl_pkg::KNot;
            MLt:     t0.kind = csl_pkg::KLess;
            MGt:     t0.kind = csl_pkg::KGreater;
            default: t0.kind = csl_pkg::KAssign;
          endcase
        end
      end
      MChar1: begin
        if (char_i == 8'h00) begin
          v0 = 1'b1; pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrQuote;
        end else begin lit_d = char_i; mode_d = MChar2; end
      end
      MChar2: begin
        v0 = 1'b1;
        if (char_i == 8'h27) begin
          t0.kind = csl_pkg::KChar; t0.cval = lit_q; mode_d = MStart;
        end else begin
          pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrQuote;
        end
      end
      MString: begin
        if (char_i == 8'h22) begin
          v0 = 1'b1; t0.kind = csl_pkg::KString; t0.len = 16'(span); mode_d = MStart;
        end else if (char_i == 8'h00) begin
          v0 = 1'b1; pend = 1'b1; mode_d = MDrop;
          t0.kind = csl_pkg::KError; t0.err = csl_pkg::ErrDquote;
        end
      end
      MDrop: begin
        if (char_i == 8'h00) begin
          v0 = 1'b1; restart = 1'b1; t0.kind = csl_pkg::KEnd; t0.start = 16'(pos_q);
        end
      end
      default: pend = 1'b1;
    endcase
    // an error token stays in drop mode; a zero byte then still gives END
    if (pend && mode_d == MDrop) begin
      if (char_i == 8'h00) begin
        v1 = 1'b1; restart = 1'b1;
        t1.kind = csl_pkg::KEnd; t1.line = 16'(line_q); t1.start = 16'(pos_q);
      end
    end else if (pend) begin
      tstart_d = pos_q;
      mode_d = MStart;
      t1.line = 16'(line_q); t1.start = 16'(pos_q);
      case (char_i)
        8'h20, 8'h09: ;
        8'h0D: begin
          if (line_q != LineTop) line_d = line_q + 1'b1;
          new_cr = 1'b1;
        end
        8'h0A: if (!cr_q && line_q != LineTop) line_d = line_q + 1'b1;
        8'h00: begin v1 = 1'b1; restart = 1'b1; t1.kind = csl_pkg::KEnd; end
        ",": begin v1 = 1'b1; t1.kind = csl_pkg::KComma; end
        ";": begin v1 = 1'b1; t1.kind = csl_pkg::KSemi; end
        "(": begin v1 = 1'b1; t1.kind = csl_pkg::KLpar; end
        ")": begin v1 = 1'b1; t1.kind = csl_pkg::KRpar; end
        "[": begin v1 = 1'b1; t1.kind = csl_pkg::KLbrk; end
        "]": begin v1 = 1'b1; t1.kind = csl_pkg::KRbrk; end
        "{": begin v1 = 1'b1; t1.kind = csl_pkg::KLacc; end
        "}": begin v1 = 1'b1; t1.kind = csl_pkg::KRacc; end
        "+": begin v1 = 1'b1; t1.kind = csl_pkg::KAdd; end
        "-": begin v1 = 1'b1; t1.kind = csl_pkg::KSub; end
        "*": begin v1 = 1'b1; t1.kind = csl_pkg::KMul; end
        "/": mode_d = MSlash;
        "&": mode_d = MAmp;
        "|": mode_d = MBar;
        "!": mode_d = MBang;
        "<": mode_d = MLt;
        ">": mode_d = MGt;
        "=": mode_d = MEq;
        8'h27: mode_d = MChar1;
        8'h22: begin mode_d = MString; tstart_d = pos_q + 1'b1; end
        default: begin
          if (csl_pkg::is_alpha(char_i)) begin
            mode_d = MIdent; kbuf_d[0] = char_i; ilen_d = csl_pkg::KeyLenW'(1);
          end else if (csl_pkg::is_digit(char_i)) begin
            mode_d = MInt; acc_d = {23'd0, dig};
          end else begin
            v1 = 1'b1; mode_d = MDrop;
            t1.kind = csl_pkg::KError; t1.err = csl_pkg::ErrChar;
          end
        end
      endcase
    end
    pos_d = pos_q + 1'b1;
    cr_d  = new_cr;
    if (restart) begin
      mode_d = MStart; line_d = csl_pkg::LineBits'(1); pos_d = '0; tstart_d = '0;
      acc_d = '0; ilen_d = '0; cr_d = 1'b0; lit_d = '0;
    end
  end

  // tokens pack to the low slot when only the second pass produced one
  assign ov1        = v0 || v1;
  assign tok0_vld_o = ov1;
  assign tok0_o     = v0 ? t0 : t1;
  assign tok1_vld_o = v0 && v1;
  assign tok1_o     = t1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MStart; line_q <= csl_pkg::LineBits'(1); pos_q <= '0; tstart_q <= '0;
      acc_q <= '0; ilen_q <= '0; cr_q <= 1'b0; lit_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; line_q <= line_d; pos_q <= pos_d; tstart_q <= tstart_d;
      acc_q <= acc_d; ilen_q <= ilen_d; cr_q <= cr_d; lit_q <= lit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) kbuf_q <= kbuf_d;
  end

endmodule

>>> rtl/core/c_subset_lexer.sv
// c_subset_lexer: top level, input register, lexer core and two-entry token queue
// depends on csl_pkg and csl_core
//
//   channel | handshake            | payload
//   in      | in_valid_i/in_ready_o | char_in_i
//   out     | out_valid_o/out_ready_i | token fields, last_o
//
// one byte per cycle while the queue has room: the core steps on the registered
// byte once its tokens fit; a byte gives at most two tokens, which enter a
// two-entry queue and leave one per cycle while out_ready_i is high, so a
// two-token byte holds the input until the queue can take both words
// reset clears the lexer state but the keyword buffer, and empties the queue;
// output stalls back up through the queue and input register to in_ready_o
module c_subset_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] line_number_o,
  output logic [30:0] int_value_o,
  output logic [7:0]  char_value_o,
  output logic [15:0] start_pos_o,
  output logic [15:0] lexeme_length_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  logic       ib_vld_q;
  logic [7:0] ib_char_q;
  logic       step;
  logic       v0, v1;
  csl_pkg::token_t t0, t1;

  // queue entries with last flag
  csl_pkg::token_t q_tok_q [2];
  csl_pkg::token_t q_tok_d [2];
  logic            q_last_q [2];
  logic            q_last_d [2];
  logic [1:0]      q_cnt_q;
  logic            pop;
  logic [1:0]      nt, cnt_after_pop;

  csl_core u_core (
    .clk_i, .rst_ni, .step_i(step), .char_i(ib_char_q),
    .tok0_vld_o(v0), .tok0_o(t0), .tok1_vld_o(v1), .tok1_o(t1)
  );

  assign pop           = out_valid_o && out_ready_i;
  assign cnt_after_pop = q_cnt_q - {1'b0, pop};
  assign nt            = {1'b0, v0} + {1'b0, v1};
  // core byte steps when its tokens fit in the queue
  assign step       = ib_vld_q && ({1'b0, cnt_after_pop} + {1'b0, nt} <= 3'd2);
  assign in_ready_o = !ib_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ib_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      ib_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) ib_char_q <= char_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= cnt_after_pop + (step ? nt : 2'd0);
    end
  end

  always_comb begin
    q_tok_d  = q_tok_q;
    q_last_d = q_last_q;
    if (pop) begin
      q_tok_d[0]  = q_tok_q[1];
      q_last_d[0] = q_last_q[1];
    end
    if (step && v0) begin
      if (cnt_after_pop == 2'd0) begin
        q_tok_d[0] = t0; q_last_d[0] = !v1;
        if (v1) begin q_tok_d[1] = t1; q_last_d[1] = 1'b1; end
      end else begin
        q_tok_d[1] = t0; q_last_d[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_tok_q  <= q_tok_d;
    q_last_q <= q_last_d;
  end

  assign out_valid_o     = q_cnt_q != 2'd0;
  assign token_kind_o    = q_tok_q[0].kind;
  assign line_number_o   = q_tok_q[0].line;
  assign int_value_o     = q_tok_q[0].ival;
  assign char_value_o    = q_tok_q[0].cval;
  assign start_pos_o     = q_tok_q[0].start;
  assign lexeme_length_o = q_tok_q[0].len;
  assign error_code_o    = q_tok_q[0].err;
  assign last_o          = q_last_q[0];

endmodule

>>> rtl/core/csl_checker.sv
// csl_checker: port-level assertions for c_subset_lexer, bound to the top level
// depends on csl_pkg
module csl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  token_kind_o,
  input logic [15:0] line_number_o,
  input logic [30:0] int_value_o,
  input logic [2:0]  error_code_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o))
    else $error("output word changed while stalled");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != csl_pkg::ErrNone |-> token_kind_o == csl_pkg::KError)
    else $error("error code on non-error word");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == csl_pkg::KEnd |-> last_o && line_number_o != 16'd0)
    else $error("end word not last");

  a_ival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != csl_pkg::KInt |-> int_value_o == 31'd0)
    else $error("value on non-int word");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (.*);
